// ----- rtl/lptt_pkg.sv -----
// ----------------------------------------------------------------------------
// lptt_pkg
// Types, codes and constants shared by the lidar point ring and time tagger.
// ----------------------------------------------------------------------------
package lptt_pkg;

  // Angles are signed radians in units of 2^-14.
  localparam logic signed [21:0] ANG_PI            = 22'sd51472;
  localparam logic signed [21:0] ANG_HALF_PI       = 22'sd25736;
  localparam logic signed [21:0] ANG_THREE_HALF_PI = 22'sd77208;
  localparam logic signed [21:0] ANG_TWO_PI        = 22'sd102944;
  localparam logic signed [21:0] ANG_THREE_PI      = 22'sd154416;

  // CORDIC angle accumulator is Q30.
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;

  localparam int CORD_W     = 52;  // CORDIC x/y datapath width
  localparam int ACC_W      = 34;  // CORDIC angle accumulator width
  localparam int SQRT_ITERS = 32;  // one result bit per iteration
  localparam int DIV_W      = 40;  // dividend and quotient width

  localparam logic [48:0] NEAR_LIMIT = 49'd100;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  localparam logic [1:0] STAT_KEPT = 2'd0;
  localparam logic [1:0] STAT_NEAR = 2'd1;
  localparam logic [1:0] STAT_RING = 2'd2;

  localparam logic [1:0] REG_VERTICAL_LOW = 2'd0;
  localparam logic [1:0] REG_RINGS_PER_RAD = 2'd1;
  localparam logic [1:0] REG_RING_COUNT = 2'd2;
  localparam logic [1:0] REG_SCAN_PERIOD = 2'd3;

  typedef struct packed {
    logic signed [16:0] vertical_low;
    logic [23:0]        rings_per_radian;
    logic [6:0]         ring_count;
    logic [17:0]        scan_period;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_NEAR, S_SQRT, S_ELEV_INIT, S_ELEV,
    S_RING_MUL, S_RING_CHK, S_AZIM, S_UNWRAP, S_TIME_MUL, S_DIV_INIT, S_DIV,
    S_SAT, S_OUT, S_BS_INIT, S_BS_START, S_BS_SAVE, S_BS_END, S_BS_SWEEP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SET_NEAR, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_CORD_ELEV, OP_CORD_AZIM, OP_CORD_STEP, OP_RING_MUL,
    OP_RING_BAD, OP_RING_OK, OP_UNWRAP, OP_TIME_MUL, OP_DIV_INIT, OP_NO_SWEEP,
    OP_DIV_STEP, OP_SAT, OP_OUT, OP_SAVE_START, OP_SWEEP
  } op_t;

  typedef struct packed {
    logic near;
    logic ring_ok;
    logic den_pos;
    logic sqrt_last;
    logic cord_last;
    logic div_last;
    logic out_free;
  } status_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lptt_regs.sv -----
// ----------------------------------------------------------------------------
// lptt_regs
// APB register file holding the elevation, ring and sweep settings.
// ----------------------------------------------------------------------------
module lptt_regs
  import lptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertical_low     <= -17'sd4289;
      cfg_r.rings_per_radian <= 24'd982529;
      cfg_r.ring_count       <= 7'd16;
      cfg_r.scan_period      <= 18'd100000;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_VERTICAL_LOW:  cfg_r.vertical_low     <= pwdata[16:0];
        REG_RINGS_PER_RAD: cfg_r.rings_per_radian <= pwdata[23:0];
        REG_RING_COUNT:    cfg_r.ring_count       <= pwdata[6:0];
        REG_SCAN_PERIOD:   cfg_r.scan_period      <= pwdata[17:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_VERTICAL_LOW:  prdata = {15'b0, cfg_r.vertical_low};
      REG_RINGS_PER_RAD: prdata = {8'b0, cfg_r.rings_per_radian};
      REG_RING_COUNT:    prdata = {25'b0, cfg_r.ring_count};
      REG_SCAN_PERIOD:   prdata = {14'b0, cfg_r.scan_period};
    endcase
  end

endmodule

// ----- rtl/lptt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lptt_ctrl
// Sequencer that steps the datapath through one begin-scan or point item.
// ----------------------------------------------------------------------------
module lptt_ctrl
  import lptt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_action,
  output logic    in_ready,
  input  status_t st,
  output op_t     op
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = (in_action == ACT_BEGIN) ? S_BS_INIT : S_SQ_X;
        end
      end
      S_SQ_X: begin
        op        = OP_SQ_X;
        state_nxt = S_SQ_Y;
      end
      S_SQ_Y: begin
        op        = OP_SQ_Y;
        state_nxt = S_SQ_Z;
      end
      S_SQ_Z: begin
        op        = OP_SQ_Z;
        state_nxt = S_NEAR;
      end
      S_NEAR: begin
        if (st.near) begin
          op        = OP_SET_NEAR;
          state_nxt = S_OUT;
        end else begin
          op        = OP_SQRT_INIT;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        op = OP_SQRT_STEP;
        if (st.sqrt_last) state_nxt = S_ELEV_INIT;
      end
      S_ELEV_INIT: begin
        op        = OP_CORD_ELEV;
        state_nxt = S_ELEV;
      end
      S_ELEV: begin
        op = OP_CORD_STEP;
        if (st.cord_last) state_nxt = S_RING_MUL;
      end
      S_RING_MUL: begin
        op        = OP_RING_MUL;
        state_nxt = S_RING_CHK;
      end
      S_RING_CHK: begin
        if (st.ring_ok) begin
          op        = OP_RING_OK;
          state_nxt = S_AZIM;
        end else begin
          op        = OP_RING_BAD;
          state_nxt = S_OUT;
        end
      end
      S_AZIM: begin
        op = OP_CORD_STEP;
        if (st.cord_last) state_nxt = S_UNWRAP;
      end
      S_UNWRAP: begin
        op        = OP_UNWRAP;
        state_nxt = S_TIME_MUL;
      end
      S_TIME_MUL: begin
        op        = OP_TIME_MUL;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        if (st.den_pos) begin
          op        = OP_DIV_INIT;
          state_nxt = S_DIV;
        end else begin
          op        = OP_NO_SWEEP;
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (st.div_last) state_nxt = S_SAT;
      end
      S_SAT: begin
        op        = OP_SAT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_BS_INIT: begin
        op        = OP_CORD_AZIM;
        state_nxt = S_BS_START;
      end
      S_BS_START: begin
        op = OP_CORD_STEP;
        if (st.cord_last) state_nxt = S_BS_SAVE;
      end
      S_BS_SAVE: begin
        op        = OP_SAVE_START;
        state_nxt = S_BS_END;
      end
      S_BS_END: begin
        op = OP_CORD_STEP;
        if (st.cord_last) state_nxt = S_BS_SWEEP;
      end
      S_BS_SWEEP: begin
        op        = OP_SWEEP;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/lptt_dp.sv -----
// ----------------------------------------------------------------------------
// lptt_dp
// Datapath: shared multiplier, bit-serial square root, iterative CORDIC,
// restoring divider, sweep state and the output register.
// ----------------------------------------------------------------------------
module lptt_dp
  import lptt_pkg::*;
#(
  parameter int MAX_RINGS    = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  op_t                op,
  output status_t            st,
  input  logic signed [23:0] in_x,
  input  logic signed [23:0] in_y,
  input  logic signed [23:0] in_z,
  input  logic signed [23:0] in_end_x,
  input  logic signed [23:0] in_end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [5:0]         out_ring,
  output logic signed [19:0] out_rel_time,
  output logic signed [19:0] out_azimuth
);

  localparam int RING_CAP = (MAX_RINGS < 64) ? MAX_RINGS : 64;

  // Latched item
  logic signed [23:0] x_r, y_r, z_r, ex_r, ey_r;

  // Shared iteration counter
  logic [5:0] cnt_r;

  // Multiplier
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic [47:0]        sq_r;
  logic               near_r;

  // Square root
  logic [63:0] rem_r, res_r, sq_bit, sq_trial;
  logic [5:0]  sq_pos;

  // CORDIC
  logic signed [CORD_W-1:0] cx_r, cy_r, cx_init, cy_init, xw, yw, xsh, ysh;
  logic signed [ACC_W-1:0]  cz_r, cz_init, cz_rnd;
  logic signed [33:0]       xv, yv;
  logic                     czero_r, czero_init;
  logic [4:0]               cshift;
  logic signed [ACC_W-1:0]  catan;
  logic signed [17:0]       cord_q14;
  logic signed [18:0]       az_neg;

  // Ring
  logic signed [18:0] elev_diff;
  logic signed [44:0] p_r;
  logic [13:0]        ring_val;
  logic [6:0]         ring_limit;
  logic [5:0]         ring_r;

  // Sweep and unwrap
  logic signed [19:0] start_r, end_r, ori_r;
  logic signed [18:0] stmp_r;
  logic               half_r;
  logic signed [21:0] a22, s22, e22, o22, o1, e0, sd, e_new;
  logic               hp_set;
  logic signed [20:0] den21, ori_diff;

  // Divider
  logic signed [39:0] tprod_r;
  logic [DIV_W-1:0]   num_r;
  logic [21:0]        drem_r, dshift;
  logic               neg_r;
  logic               qbit;
  logic signed [19:0] rel_sat;

  // Staged result and output register
  logic [1:0]         res_status_r;
  logic [5:0]         res_ring_r;
  logic signed [19:0] res_rel_r, res_az_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [5:0]         out_ring_r;
  logic signed [19:0] out_rel_r, out_az_r;

  // ---------------- multiplier operand selection
  assign elev_diff = 19'(cord_q14) - 19'(cfg.vertical_low);
  assign ori_diff  = 21'(ori_r) - 21'(start_r);

  always_comb begin
    mul_a = 25'(x_r);
    mul_b = 25'(x_r);
    unique case (op)
      OP_SQ_Y: begin
        mul_a = 25'(y_r);
        mul_b = 25'(y_r);
      end
      OP_SQ_Z: begin
        mul_a = 25'(z_r);
        mul_b = 25'(z_r);
      end
      OP_RING_MUL: begin
        mul_a = 25'(elev_diff);
        mul_b = $signed({1'b0, cfg.rings_per_radian});
      end
      OP_TIME_MUL: begin
        mul_a = 25'(ori_diff);
        mul_b = $signed({7'b0, cfg.scan_period});
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------- square root, one result bit per step
  assign sq_pos   = 6'd62 - {cnt_r[4:0], 1'b0};
  assign sq_bit   = 64'd1 << sq_pos;
  assign sq_trial = res_r + sq_bit;

  // ---------------- CORDIC start vector and micro-rotation
  always_comb begin
    yv = {{2{y_r[23]}}, y_r, 8'b0};
    xv = {{2{x_r[23]}}, x_r, 8'b0};
    unique case (op)
      OP_CORD_ELEV: begin
        yv = {{2{z_r[23]}}, z_r, 8'b0};
        xv = {2'b0, res_r[31:0]};
      end
      OP_SAVE_START: begin
        yv = {{2{ey_r[23]}}, ey_r, 8'b0};
        xv = {{2{ex_r[23]}}, ex_r, 8'b0};
      end
      default: ;
    endcase
    czero_init = (xv == '0) && (yv == '0);
    xw = {{2{xv[33]}}, xv, 16'b0};
    yw = {{2{yv[33]}}, yv, 16'b0};
    cx_init = xw;
    cy_init = yw;
    cz_init = '0;
    // Left half plane: pre-rotate by a quarter turn.
    if (xw < 0) begin
      if (yw >= 0) begin
        cx_init = yw;
        cy_init = -xw;
        cz_init = Q30_HALF_PI;
      end else begin
        cx_init = -yw;
        cy_init = xw;
        cz_init = -Q30_HALF_PI;
      end
    end
  end

  assign cshift   = cnt_r[4:0];
  assign xsh      = cx_r >>> cshift;
  assign ysh      = cy_r >>> cshift;
  assign catan    = $signed({3'b0, atan_q30(cshift)});
  assign cz_rnd   = cz_r + 34'sd32768;
  assign cord_q14 = czero_r ? 18'sd0 : cz_rnd[33:16];
  assign az_neg   = -19'(cord_q14);

  // ---------------- ring range check
  assign ring_val   = p_r[44] ? 14'd0 : p_r[43:30];
  assign ring_limit = (cfg.ring_count < 7'(RING_CAP)) ? cfg.ring_count : 7'(RING_CAP);

  // ---------------- azimuth unwrap against the sweep
  assign a22 = 22'(az_neg);
  assign s22 = 22'(start_r);
  assign e22 = 22'(end_r);

  always_comb begin
    o1     = a22 + ANG_TWO_PI;
    hp_set = 1'b0;
    if (!half_r) begin
      if (a22 < s22 - ANG_HALF_PI) o22 = a22 + ANG_TWO_PI;
      else if (a22 > s22 + ANG_THREE_HALF_PI) o22 = a22 - ANG_TWO_PI;
      else o22 = a22;
      hp_set = (o22 - s22) > ANG_PI;
    end else begin
      if (o1 < e22 - ANG_THREE_HALF_PI) o22 = o1 + ANG_TWO_PI;
      else if (o1 > e22 + ANG_HALF_PI) o22 = o1 - ANG_TWO_PI;
      else o22 = o1;
    end
  end

  // End azimuth of a new sweep, corrected to lie pi..3pi past the start.
  always_comb begin
    e0 = a22 + ANG_TWO_PI;
    sd = e0 - 22'(stmp_r);
    if (sd > ANG_THREE_PI) e_new = e0 - ANG_TWO_PI;
    else if (sd < ANG_PI) e_new = e0 + ANG_TWO_PI;
    else e_new = e0;
  end

  // ---------------- divider and saturation
  assign den21  = 21'(end_r) - 21'(start_r);
  assign dshift = {drem_r[20:0], num_r[DIV_W-1]};
  assign qbit   = dshift >= {1'b0, den21};

  always_comb begin
    if (!neg_r) begin
      rel_sat = (num_r > 40'd524287) ? 20'sd524287 : $signed(num_r[19:0]);
    end else begin
      rel_sat = (num_r > 40'd524288) ? -20'sd524288 : -$signed(num_r[19:0]);
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        x_r  <= in_x;
        y_r  <= in_y;
        z_r  <= in_z;
        ex_r <= in_end_x;
        ey_r <= in_end_y;
      end
      OP_SQ_X: sq_r <= prod[47:0];
      OP_SQ_Y: sq_r <= sq_r + prod[47:0];
      OP_SQ_Z: near_r <= ({1'b0, sq_r} + prod[48:0]) < NEAR_LIMIT;
      OP_SET_NEAR: begin
        res_status_r <= STAT_NEAR;
        res_ring_r   <= '0;
        res_rel_r    <= '0;
        res_az_r     <= '0;
      end
      OP_SQRT_INIT: begin
        rem_r <= {sq_r, 16'b0};
        res_r <= '0;
        cnt_r <= '0;
      end
      OP_SQRT_STEP: begin
        if (rem_r >= sq_trial) begin
          rem_r <= rem_r - sq_trial;
          res_r <= (res_r >> 1) + sq_bit;
        end else begin
          res_r <= res_r >> 1;
        end
        cnt_r <= cnt_r + 6'd1;
      end
      OP_CORD_ELEV, OP_CORD_AZIM, OP_SAVE_START: begin
        cx_r    <= cx_init;
        cy_r    <= cy_init;
        cz_r    <= cz_init;
        czero_r <= czero_init;
        cnt_r   <= '0;
        if (op == OP_SAVE_START) stmp_r <= az_neg;
      end
      OP_CORD_STEP: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ysh;
          cy_r <= cy_r - xsh;
          cz_r <= cz_r + catan;
        end else begin
          cx_r <= cx_r - ysh;
          cy_r <= cy_r + xsh;
          cz_r <= cz_r - catan;
        end
        cnt_r <= cnt_r + 6'd1;
      end
      OP_RING_MUL: p_r <= prod[44:0] + 45'sd536870912;
      OP_RING_BAD: begin
        res_status_r <= STAT_RING;
        res_ring_r   <= '0;
        res_rel_r    <= '0;
        res_az_r     <= '0;
      end
      OP_RING_OK: begin
        ring_r  <= ring_val[5:0];
        cx_r    <= cx_init;
        cy_r    <= cy_init;
        cz_r    <= cz_init;
        czero_r <= czero_init;
        cnt_r   <= '0;
      end
      OP_UNWRAP:   ori_r <= o22[19:0];
      OP_TIME_MUL: tprod_r <= prod[39:0];
      OP_DIV_INIT: begin
        num_r  <= (tprod_r < 0) ? DIV_W'(-tprod_r) : DIV_W'(tprod_r);
        neg_r  <= tprod_r < 0;
        drem_r <= '0;
        cnt_r  <= '0;
      end
      OP_NO_SWEEP: begin
        res_status_r <= STAT_KEPT;
        res_ring_r   <= ring_r;
        res_rel_r    <= '0;
        res_az_r     <= ori_r;
      end
      OP_DIV_STEP: begin
        drem_r <= qbit ? (dshift - {1'b0, den21}) : dshift;
        num_r  <= {num_r[DIV_W-2:0], qbit};
        cnt_r  <= cnt_r + 6'd1;
      end
      OP_SAT: begin
        res_status_r <= STAT_KEPT;
        res_ring_r   <= ring_r;
        res_rel_r    <= rel_sat;
        res_az_r     <= ori_r;
      end
      OP_OUT: begin
        out_status_r <= res_status_r;
        out_ring_r   <= res_ring_r;
        out_rel_r    <= res_rel_r;
        out_az_r     <= res_az_r;
      end
      default: ;
    endcase
  end

  // ---------------- sweep state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      end_r       <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_SWEEP) begin
        start_r <= 20'(stmp_r);
        end_r   <= e_new[19:0];
        half_r  <= 1'b0;
      end else if (op == OP_UNWRAP && hp_set) begin
        half_r <= 1'b1;
      end
      if (op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign st.near      = near_r;
  assign st.ring_ok   = (p_r > -45'sd1073741824) && ({1'b0, ring_val} < {8'b0, ring_limit});
  assign st.den_pos   = den21 > 0;
  assign st.sqrt_last = cnt_r == 6'(SQRT_ITERS - 1);
  assign st.cord_last = cnt_r == 6'(CORDIC_STEPS - 1);
  assign st.div_last  = cnt_r == 6'(DIV_W - 1);
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_ring     = out_ring_r;
  assign out_rel_time = out_rel_r;
  assign out_azimuth  = out_az_r;

endmodule

// ----- rtl/lidar_point_ring_time_tagger.sv -----
// ----------------------------------------------------------------------------
// lidar_point_ring_time_tagger
// Ring and sweep-relative time tagging of rotating multi-beam lidar points.
// ----------------------------------------------------------------------------
// One item is processed at a time, and the block is ready for the next item
// in the cycle after the previous one finishes. A begin-scan item runs two
// passes through the iterative CORDIC. A kept point runs the 32-step square
// root, two CORDIC passes and the 40-step restoring divider that turns azimuth
// into time. Before the first begin-scan item there is no sweep, so a kept
// point skips the divider. The finished beat sits in an output register, so
// the next item is accepted while it waits to be taken. A further result holds
// the block, and with it the input, until that register is free.
module lidar_point_ring_time_tagger
  import lptt_pkg::*;
#(
  parameter int MAX_RINGS    = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [23:0] in_x,
  input  logic signed [23:0] in_y,
  input  logic signed [23:0] in_z,
  input  logic signed [23:0] in_end_x,
  input  logic signed [23:0] in_end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [5:0]         out_ring,
  output logic signed [19:0] out_rel_time,
  output logic signed [19:0] out_azimuth,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t    cfg;
  op_t     op;
  status_t st;

  lptt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .st        (st),
    .op        (op)
  );

  lptt_dp #(
    .MAX_RINGS    (MAX_RINGS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .op           (op),
    .st           (st),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_ring     (out_ring),
    .out_rel_time (out_rel_time),
    .out_azimuth  (out_azimuth)
  );

endmodule

// ----- rtl/lptt_checker.sv -----
// ----------------------------------------------------------------------------
// lptt_checker
// Port-level checks of the tagger's handshakes and result encoding.
// ----------------------------------------------------------------------------
module lptt_checker
  import lptt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [5:0]         out_ring,
  input logic signed [19:0] out_rel_time,
  input logic signed [19:0] out_azimuth
);

  // A beat that is held back keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_ring)
      && $stable(out_rel_time) && $stable(out_azimuth))
    else $error("held result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_KEPT || out_status == STAT_NEAR
      || out_status == STAT_RING)
    else $error("undefined status code");

  // Dropped points carry no ring, time or angle.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_KEPT |->
      out_ring == 6'd0 && out_rel_time == 20'sd0 && out_azimuth == 20'sd0)
    else $error("dropped point with nonzero payload");

  // Items are taken one at a time, never on two consecutive edges.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind lidar_point_ring_time_tagger lptt_checker u_lptt_checker (.*);

// ----- test/lidar_point_ring_time_tagger_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_point_ring_time_tagger_tb
// Drives begin-scan and point beats through the tagger under several register
// settings and handshake patterns. A fixed-point model of ring, azimuth
// unwrap and sweep time predicts each result beat, which is compared field
// by field with what the block returns.
// ----------------------------------------------------------------------------
module lidar_point_ring_time_tagger_tb
  import lptt_pkg::*;
;

  typedef struct {
    logic               act;
    logic signed [23:0] x, y, z, ex, ey;
  } lidar_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  ring;
    logic [19:0] rel_time;
    logic [19:0] azimuth;
  } tag_t;

  localparam longint ATAN_Q30[16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768};
  localparam int ITEMS_PER_PHASE = 310;
  localparam int SETTLE_CYCLES   = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = 1'b0;
  logic signed [23:0] in_x = '0, in_y = '0, in_z = '0, in_end_x = '0, in_end_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [5:0]         out_ring;
  logic signed [19:0] out_rel_time;
  logic signed [19:0] out_azimuth;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  lidar_point_ring_time_tagger u_dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of registers and sweep state.
  longint vert_low, rings_per_rad, ring_cnt, period_us;
  longint sweep_start, sweep_end;
  bit     past_half;

  lidar_item_t pending_items[$];
  tag_t        expected_tags[$];
  int          idle_mode;
  bit          hold_arm, hold_done;
  int          hold_left;
  bit          in_took;
  int          error_count;

  function automatic longint cordic_atan2(longint yv, longint xv);
    longint cx, cy, acc, t, nx, ny;
    cx = xv * 65536;
    cy = yv * 65536;
    acc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy; cy = -t; acc = longint'(Q30_HALF_PI);
      end else begin
        cx = -cy; cy = t; acc = -longint'(Q30_HALF_PI);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i); ny = cy - (cx >>> i); acc += ATAN_Q30[i];
      end else begin
        nx = cx - (cy >>> i); ny = cy + (cx >>> i); acc -= ATAN_Q30[i];
      end
      cx = nx; cy = ny;
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Updates sweep state; returns 1 when the beat yields a result.
  function automatic bit tag_beat(lidar_item_t it, output tag_t tg);
    longint x, y, z, s, e, d2, elev, p, ring, lim, ori, rel;
    longint unsigned r;
    x = it.x; y = it.y; z = it.z;
    tg = '{default: '0};
    if (it.act == ACT_BEGIN) begin
      s = -cordic_atan2(y * 256, x * 256);
      e = -cordic_atan2(longint'(it.ey) * 256, longint'(it.ex) * 256)
          + longint'(ANG_TWO_PI);
      if (e - s > longint'(ANG_THREE_PI)) e -= longint'(ANG_TWO_PI);
      else if (e - s < longint'(ANG_PI)) e += longint'(ANG_TWO_PI);
      sweep_start = s;
      sweep_end = e;
      past_half = 1'b0;
      return 1'b0;
    end
    ring = 0; rel = 0; ori = 0;
    d2 = x * x + y * y + z * z;
    if (d2 < 100) begin
      tg.status = STAT_NEAR;
    end else begin
      r = floor_sqrt(longint'(x * x + y * y) << 16);
      elev = cordic_atan2(z * 256, longint'(r));
      p = (elev - vert_low) * rings_per_rad + (64'sd1 << 29);
      ring = p / (64'sd1 << 30);
      lim = (ring_cnt > 64) ? 64 : ring_cnt;
      if (ring < 0 || ring >= lim) begin
        tg.status = STAT_RING;
        ring = 0;
      end else begin
        tg.status = STAT_KEPT;
        s = sweep_start; e = sweep_end;
        ori = -cordic_atan2(y * 256, x * 256);
        if (!past_half) begin
          if (ori < s - longint'(ANG_HALF_PI)) ori += longint'(ANG_TWO_PI);
          else if (ori > s + longint'(ANG_THREE_HALF_PI)) ori -= longint'(ANG_TWO_PI);
          if (ori - s > longint'(ANG_PI)) past_half = 1'b1;
        end else begin
          ori += longint'(ANG_TWO_PI);
          if (ori < e - longint'(ANG_THREE_HALF_PI)) ori += longint'(ANG_TWO_PI);
          else if (ori > e + longint'(ANG_HALF_PI)) ori -= longint'(ANG_TWO_PI);
        end
        if (e - s > 0) begin
          rel = period_us * (ori - s) / (e - s);
          if (rel > 524287) rel = 524287;
          if (rel < -524288) rel = -524288;
        end
      end
    end
    tg.ring = ring[5:0];
    tg.rel_time = rel[19:0];
    tg.azimuth = ori[19:0];
    return 1'b1;
  endfunction

  // Driver: holds a beat until taken, then offers the next or idles.
  always @(negedge clk) begin
    if (!(in_valid && !in_took)) begin
      if (pending_items.size() > 0 &&
          !((idle_mode == 1 && $urandom_range(99) < 70) ||
            (idle_mode == 3 && $urandom_range(99) < 11))) begin
        lidar_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_action <= it.act;
        in_x <= it.x; in_y <= it.y; in_z <= it.z;
        in_end_x <= it.ex; in_end_y <= it.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side ready, including one long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else begin
      out_ready <= !((idle_mode == 2 && $urandom_range(99) < 70) ||
                     (idle_mode == 3 && $urandom_range(99) < 11));
    end
  end

  // Monitor: predicts accepted beats and checks result beats.
  always @(posedge clk) begin
    lidar_item_t it;
    tag_t        tg, want;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      it = '{in_action, in_x, in_y, in_z, in_end_x, in_end_y};
      if (tag_beat(it, tg)) expected_tags.insert(expected_tags.size(), tg);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        $error("result beat with no expectation waiting");
        error_count++;
      end else begin
        want = expected_tags.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_ring !== want.ring) begin
          $error("ring: expected %0d, got %0d", want.ring, out_ring);
          error_count++;
        end
        if (out_rel_time !== want.rel_time) begin
          $error("rel_time: expected %0d, got %0d",
                 $signed(want.rel_time), out_rel_time);
          error_count++;
        end
        if (out_azimuth !== want.azimuth) begin
          $error("azimuth: expected %0d, got %0d",
                 $signed(want.azimuth), out_azimuth);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val[31:0];
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_VERTICAL_LOW:  vert_low = val;
      REG_RINGS_PER_RAD: rings_per_rad = val;
      REG_RING_COUNT:    ring_cnt = val;
      default:           period_us = val;
    endcase
  endtask

  task automatic set_regs(longint vl, longint rpr, longint rc, longint sp);
    write_reg(REG_VERTICAL_LOW, vl);
    write_reg(REG_RINGS_PER_RAD, rpr);
    write_reg(REG_RING_COUNT, rc);
    write_reg(REG_SCAN_PERIOD, sp);
  endtask

  function automatic logic signed [23:0] clamp24(real v);
    if (v > 8388607.0) return 24'sh7FFFFF;
    if (v < -8388608.0) return 24'sh800000;
    return 24'($rtoi(v));
  endfunction

  task automatic push(logic act, logic signed [23:0] x, y, z, ex, ey);
    lidar_item_t it;
    it = '{act, x, y, z, ex, ey};
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_noise();
    case ($urandom_range(3))
      0: push(ACT_POINT, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom));
      1: push(ACT_POINT, 24'($signed($urandom_range(18)) - 9),
              24'($signed($urandom_range(18)) - 9), 24'($signed($urandom_range(18)) - 9),
              24'($urandom), 24'($urandom));
      2: push(ACT_BEGIN, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom));
      default: push(ACT_POINT, 24'($urandom_range(2000)), 24'($urandom),
                    24'($urandom_range(4000)), 24'($urandom), 24'($urandom));
    endcase
  endtask

  // One sweep: begin-scan beat, then points walking around the circle.
  task automatic push_sweep(int n);
    real th0, th, rng, el, pi, vl_rad, rpr_rad;
    pi = 3.14159265358979;
    th0 = ($urandom_range(20000) / 10000.0 - 1.0) * pi;
    rng = 1000.0 + $urandom_range(100000);
    push(ACT_BEGIN, clamp24(rng * $cos(th0)), clamp24(-rng * $sin(th0)), 24'($urandom),
         clamp24(rng * $cos(th0 + 1.97 * pi)), clamp24(-rng * $sin(th0 + 1.97 * pi)));
    vl_rad = vert_low / 16384.0;
    rpr_rad = rings_per_rad / 65536.0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        push_noise();
      end else begin
        th = th0 + 2.0 * pi * k / n + ($signed($urandom_range(200)) - 100) / 2000.0;
        rng = 20.0 + $urandom_range(200000);
        if (rpr_rad > 0.001)
          el = vl_rad + ($urandom_range(ring_cnt) + $urandom_range(99) / 100.0 - 0.02)
               / rpr_rad;
        else
          el = ($signed($urandom_range(2000)) - 1000) / 1000.0;
        if (el > 1.5) el = 1.5;
        if (el < -1.5) el = -1.5;
        push(ACT_POINT, clamp24(rng * $cos(th)), clamp24(-rng * $sin(th)),
             clamp24(rng * $tan(el)), 24'($urandom), 24'($urandom));
      end
    end
  endtask

  task automatic run_phase(int mode, int n_items);
    int start_len;
    idle_mode = mode;
    start_len = pending_items.size();
    while (pending_items.size() - start_len < n_items) begin
      if ($urandom_range(9) < 8) push_sweep($urandom_range(20, 60));
      else push_noise();
    end
    while (pending_items.size() > 0 || in_valid || expected_tags.size() > 0)
      @(posedge clk);
    // A begin-scan beat may still be in flight with no result to wait for.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    error_count = 0;
    idle_mode = 0;
    hold_arm = 1'b0;
    vert_low = -4289; rings_per_rad = 982529; ring_cnt = 16; period_us = 100000;
    sweep_start = 0; sweep_end = 0; past_half = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Points before any sweep exists, zero vector, near limit, extremes.
    push(ACT_POINT, 24'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd9, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd6, 24'sd8, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_BEGIN, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd0, 24'sd0, 24'sd500, 24'sd0, 24'sd0);
    push(ACT_BEGIN, 24'sd5000, 24'sd0, 24'sd0, 24'sd5000, 24'sd10);
    push(ACT_POINT, 24'sd5000, -24'sd5000, -24'sd100, 24'sd0, 24'sd0);
    push(ACT_POINT, -24'sd5000, -24'sd1, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, -24'sd5000, 24'sd1, -24'sd300, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd5000, 24'sd10, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd1000, 24'sd0, 24'sd900000, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd1000, 24'sd0, -24'sd900000, 24'sd0, 24'sd0);
    push(ACT_BEGIN, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    push(ACT_POINT, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    push(ACT_POINT, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000);
    push(ACT_POINT, 24'sh7FFFFF, 24'sh800000, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_BEGIN, -24'sd4000, 24'sd1, 24'sd0, -24'sd4000, -24'sd1);
    push(ACT_POINT, -24'sd4000, 24'sd2, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, 24'sd4000, 24'sd3, 24'sd0, 24'sd0, 24'sd0);
    push(ACT_POINT, -24'sd4000, -24'sd3, 24'sd0, 24'sd0, 24'sd0);
    run_phase(0, ITEMS_PER_PHASE);

    set_regs(-51472, 0, 2, 1);
    run_phase(1, ITEMS_PER_PHASE);

    set_regs(51472, 16777215, 64, 262143);
    hold_arm = 1'b1;
    run_phase(2, ITEMS_PER_PHASE);

    set_regs(-6000, 5726623, 64, 100000);
    run_phase(3, ITEMS_PER_PHASE);

    set_regs(-longint'($urandom_range(2000, 8000)), $urandom_range(500000, 3000000),
             $urandom_range(2, 64), $urandom_range(1, 262143));
    run_phase(1, ITEMS_PER_PHASE);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lptt_pkg.sv
rtl/lptt_regs.sv
rtl/lptt_ctrl.sv
rtl/lptt_dp.sv
rtl/lidar_point_ring_time_tagger.sv
rtl/lptt_checker.sv
test/lidar_point_ring_time_tagger_tb.sv
